### sv/utf8_check_and_replace_filter_unit_assert.svh
// Assertion macros for the UTF-8 check-and-replace filter
`ifndef UTF8_CHECK_AND_REPLACE_FILTER_UNIT_ASSERT_SVH
`define UTF8_CHECK_AND_REPLACE_FILTER_UNIT_ASSERT_SVH

// same-cycle implication
`define U8CR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define U8CR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/utf8cr_pkg.sv
// Shared types and constants of the UTF-8 check-and-replace filter
`default_nettype none
package utf8cr_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REPL_CHAR = 1'b0,
        CFG_VAL_ONLY  = 1'b1
    } t_cfg_idx;

    localparam logic [BYTE_W-1:0] CONT_MIN   = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_VAL  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_VAL  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_VAL  = 8'hF0;
    localparam logic [BYTE_W-1:0] REPL_RST   = 8'd63;

    typedef struct packed {
        logic [1:0] bytes_to_come;
        logic       stopped;
        logic       failed;
        logic       emitted;
    } t_str_state;

endpackage
`default_nettype wire

### sv/utf8_check_and_replace_filter_unit.sv
// Top level of the UTF-8 check-and-replace filter
// Stages: the accepted byte is held in the input reg, then its result in the result reg.
// Throughput: one byte per cycle unless the output stalls; the string state is registered.
// Stall on the output holds both stages; the input stalls only when they are full.
// Reset (synchronous, active low) clears string state, pipeline valids and registers
// to replacement 0x3F and replace mode.
`default_nettype none
module utf8_check_and_replace_filter_unit (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic [utf8cr_pkg::BYTE_W-1:0]        i_data_byte,
    input  wire logic                                 i_last_byte,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic                                      o_char_valid,
    output logic [utf8cr_pkg::BYTE_W-1:0]             o_char_out,
    output logic                                      o_string_end,
    output logic                                      o_string_ok,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [utf8cr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [utf8cr_pkg::BYTE_W-1:0]        i_cfg_data
);

    logic [utf8cr_pkg::BYTE_W-1:0] r_repl;
    logic                          r_vonly;

    logic                          r_in_valid;
    logic [utf8cr_pkg::BYTE_W-1:0] r_in_byte;
    logic                          r_in_last;

    utf8cr_pkg::t_str_state        r_st;
    utf8cr_pkg::t_str_state        n_st;

    logic                          r_out_valid;
    logic                          r_char_valid;
    logic [utf8cr_pkg::BYTE_W-1:0] r_char_out;
    logic                          r_string_end;
    logic                          r_string_ok;

    logic                          n_char_valid;
    logic [utf8cr_pkg::BYTE_W-1:0] n_char_out;
    logic                          n_string_ok;

    logic                          out_adv;
    logic                          in_adv;
    logic                          replace;

    assign out_adv     = !r_out_valid || !i_out_stall;
    assign in_adv      = !r_in_valid || out_adv;
    assign o_in_stall  = !in_adv;
    assign o_cfg_ready = 1'b1;
    assign replace     = !r_vonly;

    always_comb begin
        n_st         = r_st;
        n_char_valid = 1'b0;
        n_char_out   = '0;
        n_string_ok  = 1'b0;
        if (!r_st.failed && !r_st.stopped) begin
            if (r_st.bytes_to_come != 2'd0) begin
                if (r_in_byte >= utf8cr_pkg::CONT_MIN) begin
                    n_st.bytes_to_come = r_st.bytes_to_come - 2'd1;
                    if (r_st.bytes_to_come == 2'd1 && replace) begin
                        n_char_valid = 1'b1;
                        n_char_out   = r_repl;
                        n_st.emitted = 1'b1;
                    end
                end else begin
                    n_st.failed        = 1'b1;
                    n_st.bytes_to_come = 2'd0;
                end
            end else if (r_in_byte == '0) begin
                n_st.stopped = 1'b1;
            end else if (!r_in_byte[utf8cr_pkg::BYTE_W-1]) begin
                if (replace) begin
                    n_char_valid = 1'b1;
                    n_char_out   = r_in_byte;
                    n_st.emitted = 1'b1;
                end
            end else if ((r_in_byte & utf8cr_pkg::LEAD2_MASK) == utf8cr_pkg::LEAD2_VAL) begin
                n_st.bytes_to_come = 2'd1;
            end else if ((r_in_byte & utf8cr_pkg::LEAD3_MASK) == utf8cr_pkg::LEAD3_VAL) begin
                n_st.bytes_to_come = 2'd2;
            end else if ((r_in_byte & utf8cr_pkg::LEAD4_MASK) == utf8cr_pkg::LEAD4_VAL) begin
                n_st.bytes_to_come = 2'd3;
            end else begin
                n_st.failed = 1'b1;
            end
        end
        if (r_in_last) begin
            n_string_ok = !(n_st.failed || n_st.bytes_to_come != 2'd0)
                          && (r_vonly || n_st.emitted);
            n_st        = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repl  <= utf8cr_pkg::REPL_RST;
            r_vonly <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (utf8cr_pkg::t_cfg_idx'(i_cfg_index))
                utf8cr_pkg::CFG_REPL_CHAR: r_repl  <= i_cfg_data;
                utf8cr_pkg::CFG_VAL_ONLY:  r_vonly <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_adv) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= '0;
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_st <= n_st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_in_valid) begin
            r_char_valid <= n_char_valid;
            r_char_out   <= n_char_out;
            r_string_end <= r_in_last;
            r_string_ok  <= n_string_ok;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_char_valid = r_char_valid;
    assign o_char_out   = r_char_out;
    assign o_string_end = r_string_end;
    assign o_string_ok  = r_string_ok;

endmodule
`default_nettype wire

### sv/utf8cr_chk.sv
// Port checker of the UTF-8 check-and-replace filter, with its bind
`default_nettype none
`include "utf8_check_and_replace_filter_unit_assert.svh"
module utf8cr_chk (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_stall,
    input wire logic                              o_char_valid,
    input wire logic [utf8cr_pkg::BYTE_W-1:0]     o_char_out,
    input wire logic                              o_string_end,
    input wire logic                              o_string_ok
);

    `U8CR_ASSERT_IMP(a_ok_only_at_end, i_clk, i_rst_n, o_out_valid && o_string_ok, o_string_end, "verdict outside string end")
    `U8CR_ASSERT_IMP(a_char_zero, i_clk, i_rst_n, o_out_valid && !o_char_valid, o_char_out == '0, "char_out not cleared")
    `U8CR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result dropped under stall")
    `U8CR_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_char_out) && $stable(o_string_ok), "stalled result changed")

endmodule

bind utf8_check_and_replace_filter_unit utf8cr_chk u_utf8cr_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_char_valid (o_char_valid),
    .o_char_out   (o_char_out),
    .o_string_end (o_string_end),
    .o_string_ok  (o_string_ok)
);
`default_nettype wire

### dv/utf8_filter_checker.sv
// Checker for the UTF-8 filter: watches the channels, predicts each result and compares
module utf8_filter_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic [utf8cr_pkg::BYTE_W-1:0]      i_data_byte,
    input  logic                               i_last_byte,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic                               i_char_valid,
    input  logic [utf8cr_pkg::BYTE_W-1:0]      i_char_out,
    input  logic                               i_string_end,
    input  logic                               i_string_ok,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [utf8cr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [utf8cr_pkg::BYTE_W-1:0]      i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                          char_valid;
        logic [utf8cr_pkg::BYTE_W-1:0] char_out;
        logic                          string_end;
        logic                          string_ok;
    } t_char_result;

    t_char_result                  expected_chars[$];
    utf8cr_pkg::t_str_state        str;
    logic [utf8cr_pkg::BYTE_W-1:0] repl_char;
    logic                          check_only;
    int                            fails;

    function automatic t_char_result filter_byte(input logic [utf8cr_pkg::BYTE_W-1:0] b,
                                                 input logic last);
        t_char_result r;
        logic         replace;
        r = '0;
        replace = !check_only;
        if (!str.failed && !str.stopped) begin
            if (str.bytes_to_come != 2'd0) begin
                if (b >= utf8cr_pkg::CONT_MIN) begin
                    str.bytes_to_come = str.bytes_to_come - 2'd1;
                    if (str.bytes_to_come == 2'd0 && replace) begin
                        r.char_valid = 1'b1;
                        r.char_out   = repl_char;
                        str.emitted  = 1'b1;
                    end
                end else begin
                    str.failed        = 1'b1;
                    str.bytes_to_come = 2'd0;
                end
            end else if (b == 8'h00) begin
                str.stopped = 1'b1;
            end else if ((b & utf8cr_pkg::CONT_MIN) == 8'h00) begin
                if (replace) begin
                    r.char_valid = 1'b1;
                    r.char_out   = b;
                    str.emitted  = 1'b1;
                end
            end else if ((b & utf8cr_pkg::LEAD2_MASK) == utf8cr_pkg::LEAD2_VAL) begin
                str.bytes_to_come = 2'd1;
            end else if ((b & utf8cr_pkg::LEAD3_MASK) == utf8cr_pkg::LEAD3_VAL) begin
                str.bytes_to_come = 2'd2;
            end else if ((b & utf8cr_pkg::LEAD4_MASK) == utf8cr_pkg::LEAD4_VAL) begin
                str.bytes_to_come = 2'd3;
            end else begin
                str.failed = 1'b1;
            end
        end
        r.string_end = last;
        if (last) begin
            if (str.bytes_to_come != 2'd0)
                str.failed = 1'b1;
            r.string_ok = !str.failed && (check_only || str.emitted);
            str = '0;
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_char_result want;
        if (!i_rst_n) begin
            expected_chars.delete();
            str        = '0;
            repl_char  = utf8cr_pkg::REPL_RST;
            check_only = 1'b0;
            fails      = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (utf8cr_pkg::t_cfg_idx'(i_cfg_index))
                    utf8cr_pkg::CFG_REPL_CHAR: repl_char = i_cfg_data;
                    utf8cr_pkg::CFG_VAL_ONLY:  check_only = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                expected_chars.push_back(filter_byte(i_data_byte, i_last_byte));
            if (i_out_valid && !i_out_stall) begin
                if (expected_chars.size() == 0) begin
                    $error("result with nothing expected: char_out %0h end %0b",
                           i_char_out, i_string_end);
                    fails++;
                end else begin
                    want = expected_chars.pop_front();
                    compare_field("char_valid", int'(want.char_valid), int'(i_char_valid));
                    compare_field("char_out", int'(want.char_out), int'(i_char_out));
                    compare_field("string_end", int'(want.string_end), int'(i_string_end));
                    compare_field("string_ok", int'(want.string_ok), int'(i_string_ok));
                end
            end
        end
        o_pending    <= expected_chars.size();
        o_fail_count <= fails;
    end

endmodule

### dv/tb.sv
// Testbench top for the UTF-8 filter: clock, reset, stimulus, receiver stalls and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 750;
    localparam int LONG_HOLD   = 80;
    localparam int DRAIN_LIMIT = 2000;

    logic                             clk         = 1'b0;
    logic                             rst_n       = 1'b0;
    logic                             in_valid    = 1'b0;
    logic [utf8cr_pkg::BYTE_W-1:0]    data_byte   = '0;
    logic                             last_byte   = 1'b0;
    logic                             out_stall   = 1'b0;
    logic                             cfg_valid   = 1'b0;
    logic [utf8cr_pkg::CFG_IDX_W-1:0] cfg_index   = utf8cr_pkg::CFG_REPL_CHAR;
    logic [utf8cr_pkg::BYTE_W-1:0]    cfg_data    = '0;
    logic                             in_stall;
    logic                             out_valid;
    logic                             char_valid;
    logic [utf8cr_pkg::BYTE_W-1:0]    char_out;
    logic                             string_end;
    logic                             string_ok;
    logic                             cfg_ready;
    int                               fail_count;
    int                               pending;

    int                               items_sent   = 0;
    bit                               calm         = 1'b0;
    bit                               hold_out_req = 1'b0;

    utf8_check_and_replace_filter_unit u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_data_byte  (data_byte),
        .i_last_byte  (last_byte),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_char_valid (char_valid),
        .o_char_out   (char_out),
        .o_string_end (string_end),
        .o_string_ok  (string_ok),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    utf8_filter_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_data_byte  (data_byte),
        .i_last_byte  (last_byte),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_char_valid (char_valid),
        .i_char_out   (char_out),
        .i_string_end (string_end),
        .i_string_ok  (string_ok),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        #1_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [utf8cr_pkg::BYTE_W-1:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_bytes(input logic [utf8cr_pkg::BYTE_W-1:0] bytes[$],
                              input bit open_end);
        foreach (bytes[k])
            send_byte(bytes[k], !open_end && k == bytes.size() - 1);
    endtask

    task automatic send_string(input bit open_end);
        logic [utf8cr_pkg::BYTE_W-1:0] bytes[$];
        int                            nchar, r, ncont;
        nchar = $urandom_range(1, 6);
        for (int k = 0; k < nchar; k++) begin
            r = $urandom_range(0, 99);
            ncont = 0;
            if (r < 40) begin
                bytes.push_back(utf8cr_pkg::BYTE_W'($urandom_range(1, 127)));
            end else if (r < 60) begin
                bytes.push_back(utf8cr_pkg::BYTE_W'(utf8cr_pkg::LEAD2_VAL
                                                    | $urandom_range(0, 31)));
                ncont = 1;
            end else if (r < 75) begin
                bytes.push_back(utf8cr_pkg::BYTE_W'(utf8cr_pkg::LEAD3_VAL
                                                    | $urandom_range(0, 15)));
                ncont = 2;
            end else if (r < 87) begin
                bytes.push_back(utf8cr_pkg::BYTE_W'(utf8cr_pkg::LEAD4_VAL
                                                    | $urandom_range(0, 7)));
                ncont = 3;
            end else if (r < 91) begin
                bytes.push_back(utf8cr_pkg::BYTE_W'($urandom_range(0, 255)));
            end else if (r < 94) begin
                bytes.push_back(8'h00);
            end else if (r < 97) begin
                bytes.push_back(utf8cr_pkg::BYTE_W'(utf8cr_pkg::LEAD2_VAL
                                                    | $urandom_range(0, 31)));
                bytes.push_back(utf8cr_pkg::BYTE_W'($urandom_range(0, 127)));
            end else begin
                bytes.push_back(utf8cr_pkg::BYTE_W'(utf8cr_pkg::LEAD3_VAL
                                                    | $urandom_range(0, 15)));
                ncont = 1;
            end
            repeat (ncont)
                bytes.push_back(utf8cr_pkg::BYTE_W'(utf8cr_pkg::CONT_MIN
                                                    | $urandom_range(0, 127)));
        end
        send_bytes(bytes, open_end);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic set_config(input logic [utf8cr_pkg::BYTE_W-1:0] repl,
                              input logic check_only);
        cfg_valid <= 1'b1;
        cfg_index <= utf8cr_pkg::CFG_REPL_CHAR;
        cfg_data  <= repl;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= utf8cr_pkg::CFG_VAL_ONLY;
        cfg_data  <= {7'b0, check_only};
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : rx_side
        int stall_len;
        forever begin
            if (hold_out_req) begin
                hold_out_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end else begin
                stall_len = pick_gap();
                if (stall_len != 0) begin
                    out_stall <= 1'b1;
                    repeat (stall_len) @(posedge clk);
                end
                out_stall <= 1'b0;
                repeat (calm ? 8 : $urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        int phase, stop, settle;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_bytes('{8'h01, 8'h7F, 8'hC2, 8'h80, 8'hE2, 8'h82, 8'hAC,
                     8'hF0, 8'h9F, 8'h98, 8'h80}, 1'b0);
        send_bytes('{8'hFF, 8'h41}, 1'b0);
        send_bytes('{8'h80}, 1'b0);
        send_bytes('{8'hC3, 8'h41}, 1'b0);
        send_bytes('{8'hE2, 8'h82}, 1'b0);
        send_bytes('{8'h41, 8'h00, 8'h42}, 1'b0);
        send_bytes('{8'h00}, 1'b0);
        send_bytes('{8'hF8}, 1'b0);
        send_bytes('{8'hC2, 8'h00}, 1'b0);
        drain();
        set_config(8'h2A, 1'b1);
        send_bytes('{8'h00}, 1'b0);
        send_bytes('{8'hC2, 8'h80}, 1'b0);
        drain();

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            calm = (phase % 5 == 3);
            case (phase % 4)
                0: set_config(8'h00, phase % 3 == 1);
                1: set_config(8'hFF, phase % 3 == 1);
                default: set_config(utf8cr_pkg::BYTE_W'($urandom_range(0, 255)),
                                    phase % 3 == 1);
            endcase
            if (phase % 6 == 2) begin
                calm = 1'b1;
                hold_out_req = 1'b1;
            end
            stop = items_sent + $urandom_range(40, 80);
            while (items_sent < stop) send_string(1'b0);
            if (phase % 2 == 1)
                send_string(1'b1);
            drain();
            phase++;
        end
        calm = 1'b0;
        send_bytes('{8'h41}, 1'b0);

        in_valid <= 1'b0;
        settle = 0;
        do begin
            @(posedge clk);
            settle++;
        end while (pending != 0 && settle < DRAIN_LIMIT);
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/utf8cr_pkg.sv
sv/utf8_check_and_replace_filter_unit.sv
sv/utf8cr_chk.sv
dv/utf8_filter_checker.sv
dv/tb.sv
